// ----- sv/mf3_pkg.sv -----
`default_nettype none

package mf3_pkg;

  // Frame geometry.
  localparam int unsigned IMAGE_WIDTH  = 256;
  localparam int unsigned IMAGE_HEIGHT = 256;

  localparam int unsigned ColW = $clog2(IMAGE_WIDTH);
  localparam int unsigned RowW = $clog2(IMAGE_HEIGHT);

  localparam logic [ColW-1:0] LastCol = ColW'(IMAGE_WIDTH - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(IMAGE_HEIGHT - 1);

  // Pixel positions as they appear on the result port (low eight bits).
  localparam logic [7:0] LastColOut = 8'(IMAGE_WIDTH - 1);
  localparam logic [7:0] LastRowOut = 8'(IMAGE_HEIGHT - 1);

  // Result slots of one request, in the order they leave the block.
  localparam int unsigned ResCenter = 0;  // pixel (r-1, c-1)
  localparam int unsigned ResEdge   = 1;  // pixel (r-1, last column)
  localparam int unsigned ResBottom = 2;  // pixel (r, c) of the last row
  localparam int unsigned NumRes    = 3;

  typedef logic [7:0]      pix_t;
  typedef logic [ColW-1:0] col_t;
  typedef logic [RowW-1:0] row_t;
  typedef pix_t [8:0]      taps_t;
  typedef pix_t [5:0]      win_t;

  // Per-request bookkeeping that travels beside the sorting network.
  typedef struct packed {
    logic [NumRes-1:0] mask;    // which results this request produces
    logic              border;  // center result is a border pixel
    pix_t              bval;    // pass-through value for a border center pixel
    row_t              row;
    col_t              col;
    pix_t              mid;     // middle line value of column c
    pix_t              pix;     // incoming pixel
    logic              flast;   // bottom result is the last pixel of the frame
  } meta_t;

  // Compare and exchange: the smaller value lands at index lo.
  function automatic taps_t cswap(taps_t p, logic [3:0] lo, logic [3:0] hi);
    taps_t q;
    q = p;
    if (p[lo] > p[hi]) begin
      q[lo] = p[hi];
      q[hi] = p[lo];
    end
    return q;
  endfunction

  // Nineteen-exchange median network, split in three slices of three layers.
  function automatic taps_t med_slice_a(taps_t p);
    taps_t q;
    q = p;
    q = cswap(q, 4'd1, 4'd2); q = cswap(q, 4'd4, 4'd5); q = cswap(q, 4'd7, 4'd8);
    q = cswap(q, 4'd0, 4'd1); q = cswap(q, 4'd3, 4'd4); q = cswap(q, 4'd6, 4'd7);
    q = cswap(q, 4'd1, 4'd2); q = cswap(q, 4'd4, 4'd5); q = cswap(q, 4'd7, 4'd8);
    return q;
  endfunction

  function automatic taps_t med_slice_b(taps_t p);
    taps_t q;
    q = p;
    q = cswap(q, 4'd0, 4'd3); q = cswap(q, 4'd5, 4'd8); q = cswap(q, 4'd4, 4'd7);
    q = cswap(q, 4'd3, 4'd6); q = cswap(q, 4'd1, 4'd4); q = cswap(q, 4'd2, 4'd5);
    q = cswap(q, 4'd4, 4'd7);
    return q;
  endfunction

  function automatic taps_t med_slice_c(taps_t p);
    taps_t q;
    q = p;
    q = cswap(q, 4'd4, 4'd2);
    q = cswap(q, 4'd6, 4'd4);
    q = cswap(q, 4'd4, 4'd2);
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- sv/median_filter_3x3_core.sv -----
`default_nettype none

// Streaming 3x3 median filter for 8-bit grayscale frames sent in raster order,
// one pixel per request. Each result carries its row and column (low eight
// bits); interior pixels get the median of their 3x3 neighborhood, pixels of
// the first and last row and column pass through unchanged. Results trail the
// input by one row and one column, and the last row is echoed as it arrives.
// While the result port is not stalled, a request that yields at most one
// result is taken every clock, so the block sustains one pixel per cycle
// over most of the frame; a last-column pixel yields two results and a
// last-row pixel up to three, and the single result port then holds the
// input while they leave. A request passes stage 1 (the line memory read),
// stages 2 to 4 (the sliced sorting network) and the output register, which
// the last slice feeds. Frame_start restarts the row and column counters
// at once.
// The line memory has no clearing pass; its unwritten entries only ever feed
// border pixels, whose values do not depend on them.
module median_filter_3x3_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Pixel input
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic [7:0] pixel_in_i,
  input  wire logic       frame_start_i,
  // Result output
  output logic            valid_o,
  input  wire logic       stall_i,
  output logic [7:0]      out_row_o,
  output logic [7:0]      out_col_o,
  output logic [7:0]      pixel_out_o,
  output logic            run_last_o,
  output logic            frame_last_o
);

  // Position counters: where the next pixel lands in the frame.
  mf3_pkg::row_t row_q, row_d;
  mf3_pkg::col_t col_q, col_d;
  mf3_pkg::row_t cur_row;
  mf3_pkg::col_t cur_col;

  // One line memory holds both previous rows per column: {row r-2, row r-1}.
  logic [15:0] line_mem [mf3_pkg::IMAGE_WIDTH];
  logic [15:0] rd_q;

  // Most recent line memory write, used to forward around the memory when a
  // read and a write to the same column happen on the same edge.
  logic          wr_valid_q;
  mf3_pkg::col_t wr_addr_q;
  logic [15:0]   wr_data_q;

  // Stage 1: waiting for the line memory read data.
  logic          s1_valid_q;
  mf3_pkg::row_t s1_row_q;
  mf3_pkg::col_t s1_col_q;
  mf3_pkg::pix_t s1_pix_q;

  // Two most recent window columns, in the order upper, middle, lower.
  mf3_pkg::win_t win_q;

  // Stages 2 to 4: sorting network slices.
  logic           s2_valid_q, s3_valid_q, s4_valid_q;
  mf3_pkg::taps_t s2_taps_q, s3_taps_q, s4_taps_q;
  mf3_pkg::meta_t s2_meta_q, s3_meta_q, s4_meta_q;

  // Output register: one request with its pending results.
  logic [mf3_pkg::NumRes-1:0] em_mask_q;
  mf3_pkg::meta_t             em_meta_q;
  mf3_pkg::pix_t              em_med_q;

  // Handshake and stage movement.
  logic accept, take, load;
  logic mv1, mv2, mv3, mv4;
  logic s1_exit;

  // Stage 1 combinational results.
  logic           fwd_hit;
  mf3_pkg::pix_t  up_pix, mid_pix;
  mf3_pkg::taps_t s1_taps;
  mf3_pkg::meta_t s1_meta;
  logic           row_nz, col_nz;

  // Result selection.
  logic [mf3_pkg::NumRes-1:0] sel, rest;
  mf3_pkg::taps_t             med_taps;

  // ---------------------------------------------------------------------------
  // Stage movement. A stage loads when it is empty or its content moves on,
  // so bubbles close up and the input keeps flowing while a result waits.
  // ---------------------------------------------------------------------------
  assign take = valid_o & ~stall_i;
  assign sel  = em_mask_q & (~em_mask_q + 3'd1);   // lowest pending result
  assign rest = em_mask_q & ~sel;
  assign load = (em_mask_q == '0) | (take & (rest == '0));

  assign mv4 = load;
  assign mv3 = ~s4_valid_q | mv4;
  assign mv2 = ~s3_valid_q | mv3;
  assign mv1 = ~s2_valid_q | mv2;

  assign stall_o = s1_valid_q & ~mv1;
  assign accept  = valid_i & ~stall_o;
  assign s1_exit = s1_valid_q & mv1;

  // ---------------------------------------------------------------------------
  // Position counters, advanced at each accepted request.
  // ---------------------------------------------------------------------------
  assign cur_row = frame_start_i ? '0 : row_q;
  assign cur_col = frame_start_i ? '0 : col_q;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (cur_col == mf3_pkg::LastCol) begin
        col_d = '0;
        row_d = (cur_row == mf3_pkg::LastRow) ? '0 : cur_row + mf3_pkg::row_t'(1);
      end else begin
        col_d = cur_col + mf3_pkg::col_t'(1);
        row_d = cur_row;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: read when a request enters, written back when it leaves
  // stage 1. Consecutive requests touch different columns except after a
  // frame restart, which the forwarding register covers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_exit) begin
      line_mem[s1_col_q] <= {mid_pix, s1_pix_q};
    end
    if (accept) begin
      rd_q <= line_mem[cur_col];
    end
  end

  assign fwd_hit = wr_valid_q & (wr_addr_q == s1_col_q);
  assign up_pix  = fwd_hit ? wr_data_q[15:8] : rd_q[15:8];
  assign mid_pix = fwd_hit ? wr_data_q[7:0]  : rd_q[7:0];

  // ---------------------------------------------------------------------------
  // Stage 1: build the nine taps and decide which results the request makes.
  // ---------------------------------------------------------------------------
  assign row_nz = (s1_row_q != '0);
  assign col_nz = (s1_col_q != '0);

  always_comb begin
    s1_taps    = {s1_pix_q, mid_pix, up_pix, win_q};
    s1_meta    = '0;
    s1_meta.mask[mf3_pkg::ResCenter] = row_nz & col_nz;
    s1_meta.mask[mf3_pkg::ResEdge]   = row_nz & (s1_col_q == mf3_pkg::LastCol);
    s1_meta.mask[mf3_pkg::ResBottom] = (s1_row_q == mf3_pkg::LastRow);
    // The center pixel sits on the border when it is in row or column zero.
    s1_meta.border = (s1_row_q == mf3_pkg::row_t'(1)) | (s1_col_q == mf3_pkg::col_t'(1));
    s1_meta.bval   = win_q[4];
    s1_meta.row    = s1_row_q;
    s1_meta.col    = s1_col_q;
    s1_meta.mid    = mid_pix;
    s1_meta.pix    = s1_pix_q;
    s1_meta.flast  = (s1_row_q == mf3_pkg::LastRow) & (s1_col_q == mf3_pkg::LastCol);
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      wr_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      em_mask_q  <= '0;
      win_q      <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (s1_exit) begin
        wr_valid_q <= 1'b1;
        // Shift the window by one column.
        win_q      <= {s1_pix_q, mid_pix, up_pix, win_q[5:3]};
      end
      if (!stall_o) begin
        s1_valid_q <= accept;
      end
      if (mv1) begin
        s2_valid_q <= s1_valid_q;
      end
      if (mv2) begin
        s3_valid_q <= s2_valid_q;
      end
      if (mv3) begin
        s4_valid_q <= s3_valid_q;
      end
      if (load) begin
        em_mask_q <= s4_valid_q ? s4_meta_q.mask : '0;
      end else if (take) begin
        em_mask_q <= rest;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  assign med_taps = mf3_pkg::med_slice_c(s4_taps_q);

  always_ff @(posedge clk_i) begin
    if (s1_exit) begin
      wr_addr_q <= s1_col_q;
      wr_data_q <= {mid_pix, s1_pix_q};
    end
    if (accept) begin
      s1_row_q <= cur_row;
      s1_col_q <= cur_col;
      s1_pix_q <= pixel_in_i;
    end
    if (mv1) begin
      s2_taps_q <= s1_taps;
      s2_meta_q <= s1_meta;
    end
    if (mv2) begin
      s3_taps_q <= mf3_pkg::med_slice_a(s2_taps_q);
      s3_meta_q <= s2_meta_q;
    end
    if (mv3) begin
      s4_taps_q <= mf3_pkg::med_slice_b(s3_taps_q);
      s4_meta_q <= s3_meta_q;
    end
    if (load) begin
      em_med_q  <= med_taps[4];
      em_meta_q <= s4_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result port: the pending results of the held request leave in order.
  // ---------------------------------------------------------------------------
  assign valid_o    = (em_mask_q != '0);
  assign run_last_o = (rest == '0);

  always_comb begin
    if (sel[mf3_pkg::ResCenter]) begin
      out_row_o    = 8'(em_meta_q.row - mf3_pkg::row_t'(1));
      out_col_o    = 8'(em_meta_q.col - mf3_pkg::col_t'(1));
      pixel_out_o  = em_meta_q.border ? em_meta_q.bval : em_med_q;
      frame_last_o = 1'b0;
    end else if (sel[mf3_pkg::ResEdge]) begin
      out_row_o    = 8'(em_meta_q.row - mf3_pkg::row_t'(1));
      out_col_o    = 8'(em_meta_q.col);
      pixel_out_o  = em_meta_q.mid;
      frame_last_o = 1'b0;
    end else begin
      out_row_o    = 8'(em_meta_q.row);
      out_col_o    = 8'(em_meta_q.col);
      pixel_out_o  = em_meta_q.pix;
      frame_last_o = em_meta_q.flast;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mf3_checker.sv -----
`default_nettype none

module mf3_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       stall_o,
  input wire logic [7:0] pixel_in_i,
  input wire logic       frame_start_i,
  input wire logic       valid_o,
  input wire logic       stall_i,
  input wire logic [7:0] out_row_o,
  input wire logic [7:0] out_col_o,
  input wire logic [7:0] pixel_out_o,
  input wire logic       run_last_o,
  input wire logic       frame_last_o
);

  // A stalled request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(pixel_in_i) && $stable(frame_start_i))
    else $error("request changed while stalled");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_row_o) && $stable(out_col_o)
      && $stable(pixel_out_o) && $stable(run_last_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  // The results of one request follow each other without a gap.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !run_last_o |=> valid_o)
    else $error("gap inside the results of one request");

  // The final pixel of a frame is always the last result of its request.
  a_flast_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_last_o |-> run_last_o)
    else $error("frame end not at the end of a request's results");

  // The frame end flag sits on the bottom right pixel only.
  a_flast_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_last_o |-> out_row_o == mf3_pkg::LastRowOut
      && out_col_o == mf3_pkg::LastColOut)
    else $error("frame end flag on the wrong pixel");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .pixel_in_i    (pixel_in_i),
  .frame_start_i (frame_start_i),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .out_row_o     (out_row_o),
  .out_col_o     (out_col_o),
  .pixel_out_o   (pixel_out_o),
  .run_last_o    (run_last_o),
  .frame_last_o  (frame_last_o)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the streaming 3x3 median filter.
//
// A stimulus process fills a queue of pixel requests. A clocked driver takes
// requests from that queue, and every request that the block accepts goes
// through a software copy of the filter: two line stores, a two-column
// window and the row and column counters. That copy pushes the results the
// request must cause onto a queue of expected output pixels. A clocked
// monitor on the result port takes each result in turn and compares it,
// field by field, with the oldest expected pixel.
//
// A row is 256 pixels wide and results only start in the second row, so the
// run is a few hundred requests: a short opening in row zero with an early
// frame start, one partial frame that reaches the third row (border pixels,
// the right edge and the first medians), and a closing frame started early
// in the third row once every result owed has come out.
module tb_top;

  // One request on the pixel input.
  typedef struct {
    mf3_pkg::pix_t pix;
    logic          fs;
  } px_req_t;

  // One output pixel, as it should show up on the result port.
  typedef struct {
    logic [7:0]    row;
    logic [7:0]    col;
    mf3_pkg::pix_t value;
    logic          run_last;
    logic          frame_last;
  } px_result_t;

  typedef mf3_pkg::pix_t nine_px_t [9];

  // How pixel values are picked over a short run of requests.
  typedef enum int {
    MixFull,     // any value
    MixExtreme,  // only black and white
    MixNarrow,   // a narrow band, so the window has many ties
    MixRamp      // a rising ramp
  } pix_mix_e;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 20;

  // DUT ports.
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       valid_i       = 1'b0;
  logic       stall_o;
  logic [7:0] pixel_in_i    = 8'h00;
  logic       frame_start_i = 1'b0;
  logic       valid_o;
  logic       stall_i       = 1'b0;
  logic [7:0] out_row_o;
  logic [7:0] out_col_o;
  logic [7:0] pixel_out_o;
  logic       run_last_o;
  logic       frame_last_o;

  median_filter_3x3_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .pixel_in_i   (pixel_in_i),
    .frame_start_i(frame_start_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .pixel_out_o  (pixel_out_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

  always #10 clk_i = ~clk_i;

  // Pixel requests still to be offered, and output pixels still owed.
  px_req_t    pixel_feed[$];
  px_result_t expected_px[$];

  // Software copy of the filter state.
  mf3_pkg::pix_t upper_line  [mf3_pkg::IMAGE_WIDTH] = '{default: '0};
  mf3_pkg::pix_t middle_line [mf3_pkg::IMAGE_WIDTH] = '{default: '0};
  mf3_pkg::pix_t win_cols    [6]                    = '{default: '0};
  int unsigned   row_pos = 0;
  int unsigned   col_pos = 0;

  // Controls set by the stimulus process, always with nonblocking writes at
  // a falling edge, so the clocked processes see them at a clean edge.
  logic idle_off  = 1'b0;
  logic hold_long = 1'b0;

  // Statistics and error bookkeeping.
  int unsigned px_sent    = 0;
  int unsigned px_checked = 0;
  int unsigned edge_seen  = 0;
  int unsigned err_count  = 0;

  // Driver and monitor state.
  px_req_t     next_req;
  int unsigned src_gap   = 0;
  int unsigned sink_gap  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  px_result_t  got_px;
  px_result_t  want_px;

  // Median of nine by insertion sort: the fifth smallest value.
  function automatic mf3_pkg::pix_t median_of_nine(input nine_px_t v);
    mf3_pkg::pix_t key;
    int            j;
    for (int i = 1; i < 9; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[4];
  endfunction

  function automatic px_result_t make_px(input int unsigned r, input int unsigned c,
                                         input mf3_pkg::pix_t v);
    px_result_t p;
    p.row        = r[7:0];
    p.col        = c[7:0];
    p.value      = v;
    p.run_last   = 1'b0;
    p.frame_last = (r == mf3_pkg::IMAGE_HEIGHT - 1) && (c == mf3_pkg::IMAGE_WIDTH - 1);
    return p;
  endfunction

  // Runs one accepted pixel through the filter copy and queues the output
  // pixels it finishes: the center pixel one row and one column back, the
  // right-edge pixel of the previous row, and, in the last row, the pixel
  // itself. The final one of those carries run_last.
  task automatic filter_pixel(input mf3_pkg::pix_t pix, input logic fs);
    mf3_pkg::pix_t new_col [3];
    nine_px_t      taps;
    px_result_t    outs [3];
    int            n;
    int unsigned   r;
    int unsigned   c;
    n = 0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    new_col[0] = upper_line[c];
    new_col[1] = middle_line[c];
    new_col[2] = pix;

    if (r >= 1 && c >= 1) begin
      if (r == 1 || c == 1) begin
        // Border pixel of the first row or column passes through.
        outs[n] = make_px(r - 1, c - 1, win_cols[4]);
      end else begin
        for (int k = 0; k < 6; k++) taps[k] = win_cols[k];
        for (int k = 0; k < 3; k++) taps[6 + k] = new_col[k];
        outs[n] = make_px(r - 1, c - 1, median_of_nine(taps));
      end
      n++;
    end
    if (r >= 1 && c == mf3_pkg::IMAGE_WIDTH - 1) begin
      outs[n] = make_px(r - 1, c, new_col[1]);
      n++;
    end
    if (r == mf3_pkg::IMAGE_HEIGHT - 1) begin
      outs[n] = make_px(r, c, pix);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      outs[k].run_last = (k == n - 1);
      expected_px.push_back(outs[k]);
    end

    upper_line[c]  = middle_line[c];
    middle_line[c] = pix;
    for (int k = 0; k < 3; k++) begin
      win_cols[k]     = win_cols[k + 3];
      win_cols[k + 3] = new_col[k];
    end

    c++;
    if (c >= mf3_pkg::IMAGE_WIDTH) begin
      c = 0;
      r++;
      if (r >= mf3_pkg::IMAGE_HEIGHT) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // Driver. A request stays on the port until it is taken. Between requests
  // the sender idles now and then.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i       <= 1'b0;
      pixel_in_i    <= 8'h00;
      frame_start_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) begin
        filter_pixel(pixel_in_i, frame_start_i);
        px_sent++;
      end
      if (!valid_i || !stall_o) begin
        if (src_gap > 0) begin
          src_gap--;
          valid_i <= 1'b0;
        end else if (pixel_feed.size() == 0) begin
          valid_i <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 19) == 0) begin
          src_gap = $urandom_range(0, 15);
          valid_i <= 1'b0;
        end else begin
          next_req = pixel_feed.pop_front();
          valid_i       <= 1'b1;
          pixel_in_i    <= next_req.pix;
          frame_start_i <= next_req.fs;
        end
      end
    end
  end

  // Monitor. Checks every result taken from the port, then decides whether
  // to stall the next cycle: short random bursts, plus one long hold-off
  // that lets the block fill up and push back on the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        got_px.row        = out_row_o;
        got_px.col        = out_col_o;
        got_px.value      = pixel_out_o;
        got_px.run_last   = run_last_o;
        got_px.frame_last = frame_last_o;
        if (expected_px.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected result row %0d col %0d pixel %0d", $realtime,
                     got_px.row, got_px.col, got_px.value);
          err_count++;
        end else begin
          want_px = expected_px.pop_front();
          px_checked++;
          if (want_px.col == mf3_pkg::LastColOut) edge_seen++;
          if (got_px.row !== want_px.row || got_px.col !== want_px.col ||
              got_px.value !== want_px.value || got_px.run_last !== want_px.run_last ||
              got_px.frame_last !== want_px.frame_last) begin
            if (err_count < 10)
              $display("%0t: mismatch exp row %0d col %0d pix %0d rl %0b fl %0b,",
                       $realtime, want_px.row, want_px.col, want_px.value,
                       want_px.run_last, want_px.frame_last,
                       " got row %0d col %0d pix %0d rl %0b fl %0b",
                       got_px.row, got_px.col, got_px.value, got_px.run_last,
                       got_px.frame_last);
            err_count++;
          end
        end
      end

      if (hold_long && !hold_done) begin
        hold_left = HoldOffCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        stall_i <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 15) == 0) begin
        sink_gap = $urandom_range(0, 15);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_px(input mf3_pkg::pix_t pix, input logic fs);
    px_req_t req;
    req.pix = pix;
    req.fs  = fs;
    pixel_feed.push_back(req);
  endtask

  // Queues a raster stream of the given length. The value mix changes every
  // 32 pixels so that windows see ties, extremes and smooth areas.
  task automatic queue_stream(input int unsigned count, input logic with_start);
    pix_mix_e      mix;
    mf3_pkg::pix_t base;
    mf3_pkg::pix_t pix;
    mix  = MixFull;
    base = 8'h00;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 32 == 0) begin
        mix  = pix_mix_e'($urandom_range(0, 3));
        base = 8'($urandom_range(0, 255));
      end
      case (mix)
        MixFull:    pix = 8'($urandom_range(0, 255));
        MixExtreme: pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        MixNarrow:  pix = base + 8'($urandom_range(0, 3));
        default:    pix = base + 8'(k);
      endcase
      queue_px(pix, with_start && (k == 0));
    end
  endtask

  // Waits until every queued request has been taken and, if asked, until
  // every expected result has arrived.
  task automatic wait_drained(input logic need_results);
    while (pixel_feed.size() != 0 || valid_i ||
           (need_results && expected_px.size() != 0))
      @(negedge clk_i);
  endtask

  // Stimulus.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short directed opening: extreme and alternating pixel values on the
    // first row, then an early frame start while still in row zero.
    queue_px(8'h00, 1'b1);
    queue_px(8'hFF, 1'b0);
    queue_px(8'h55, 1'b0);
    queue_px(8'hAA, 1'b0);
    queue_px(8'h01, 1'b0);
    queue_px(8'h80, 1'b0);
    queue_px(8'h7F, 1'b0);
    queue_px(8'hFE, 1'b0);
    queue_px(8'h00, 1'b0);
    queue_px(8'hFF, 1'b0);
    queue_px(8'hFF, 1'b1);
    queue_px(8'h00, 1'b0);
    queue_px(8'hFF, 1'b0);

    // One partial frame into the third row: the border pixels of row zero,
    // the right edge of row zero and the first medians of row one.
    queue_stream(2 * mf3_pkg::IMAGE_WIDTH + $urandom_range(8, 40), 1'b1);
    // The long hold-off lands while this stream is still being offered.
    hold_long <= 1'b1;

    // The sender stops here until every result owed has come out.
    wait_drained(1'b1);

    // Last part, without idling on either side: a frame start in the third
    // row cuts the old frame short, and the new frame runs into row one.
    idle_off <= 1'b1;
    queue_stream(mf3_pkg::IMAGE_WIDTH + $urandom_range(4, 24), 1'b1);

    wait_drained(1'b1);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d pixel requests and checked %0d output pixels.", px_sent, px_checked);
    $display("Right-edge pixels checked: %0d, errors: %0d.", edge_seen, err_count);
    if (err_count == 0 && expected_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_px.size() != 0)
        $display("%0d expected output pixels never arrived.", expected_px.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Under 850 requests; even with every request causing three results and
  // every wait at its longest, a correct run stays near 1.2 ms.
  initial begin
    #10_000_000;
    $display("Timeout with %0d output pixels still owed.", expected_px.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- median_filter_3x3_core.f -----
sv/mf3_pkg.sv
sv/median_filter_3x3_core.sv
sv/mf3_checker.sv
tb/tb_top.sv
